FILE: hw/rtl/smpc_pkg.sv
// Package with the word types, command and motor codes and register map of the PWM controller.
package smpc_pkg;

  localparam int unsigned AddrWidth = 4;

  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_SET_FRONT  = 4'd1;
  localparam logic [3:0] CMD_SET_BACK   = 4'd2;
  localparam logic [3:0] CMD_INC_FRONT  = 4'd3;
  localparam logic [3:0] CMD_DEC_FRONT  = 4'd4;
  localparam logic [3:0] CMD_INC_BACK   = 4'd5;
  localparam logic [3:0] CMD_DEC_BACK   = 4'd6;
  localparam logic [3:0] CMD_MOTOR      = 4'd7;
  localparam logic [3:0] CMD_SET_LIMIT  = 4'd8;
  localparam logic [3:0] CMD_DUTY_LIMIT = 4'd9;
  localparam logic [3:0] CMD_ACCEL      = 4'd10;

  localparam logic [7:0] MOTOR_STOP     = 8'd0;
  localparam logic [7:0] MOTOR_FORWARD  = 8'd1;
  localparam logic [7:0] MOTOR_BACKWARD = 8'd2;
  localparam logic [7:0] MOTOR_LEFT     = 8'd3;
  localparam logic [7:0] MOTOR_RIGHT    = 8'd4;

  localparam logic [7:0] PAT_STOP     = 8'h00;
  localparam logic [7:0] PAT_FORWARD  = 8'h55;
  localparam logic [7:0] PAT_BACKWARD = 8'hAA;
  localparam logic [7:0] PAT_LEFT     = 8'h66;
  localparam logic [7:0] PAT_RIGHT    = 8'h99;

  localparam logic [7:0] ANGLE_MAX   = 8'd25;
  localparam logic [7:0] ANGLE_TOP   = 8'd255;
  localparam logic [7:0] ANGLE_RESET = 8'd11;
  localparam logic [7:0] DUTY_MAX    = 8'd255;
  localparam logic [7:0] LIMIT_RESET = 8'd120;

  localparam logic [7:0]  PERIOD_RESET  = 8'd200;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

  localparam logic [1:0] REG_LIMIT_FOLLOW = 2'd0;
  localparam logic [1:0] REG_PERIOD       = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic       servo_front;
    logic       servo_back;
    logic [7:0] motor_port;
    logic       timeout_pulse;
    logic [7:0] speed_now;
    logic [7:0] limit_now;
    logic [7:0] direction_now;
    logic       reversed;
    logic [7:0] angle_front_now;
    logic [7:0] angle_back_now;
  } out_t;

  typedef struct packed {
    logic        limit_follow;
    logic [7:0]  period_ticks;
    logic [15:0] timeout_periods;
  } cfg_t;

endpackage

FILE: hw/rtl/smpc_cfg.sv
// APB-style configuration register block of the PWM controller.
module smpc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smpc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output smpc_pkg::cfg_t                 cfg
);
  import smpc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_LIMIT_FOLLOW: cfg_nxt.limit_follow    = pwdata[0];
        REG_PERIOD:       cfg_nxt.period_ticks    = pwdata[7:0];
        REG_TIMEOUT:      cfg_nxt.timeout_periods = pwdata[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LIMIT_FOLLOW: prdata = {31'd0, cfg_r.limit_follow};
      REG_PERIOD:       prdata = {24'd0, cfg_r.period_ticks};
      REG_TIMEOUT:      prdata = {16'd0, cfg_r.timeout_periods};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_follow    <= 1'b0;
      cfg_r.period_ticks    <= PERIOD_RESET;
      cfg_r.timeout_periods <= TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/servo_motor_pwm_controller_unit.sv
// Top level of the two-servo and motor PWM controller with its command pipeline.
//
//   channel  ports                 word    direction
//   in       in_valid/in_ready     in_t    command and value into the block
//   out      out_valid/out_ready   out_t   pin levels and state after each word
//   cfg      psel..pready          32 bit  limit_follow, period_ticks, timeout_periods
//
// Each word is captured in the input register and then updates the state and loads
// the result register together, so a word is taken every cycle while the result is
// not stalled, and its result is held in the result register. Reset is synchronous
// and clears the valid flags and the controller state to their power-on values.
// A stalled result holds the pipeline; the input register still fills if empty.
module servo_motor_pwm_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  smpc_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output smpc_pkg::out_t                 out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smpc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import smpc_pkg::*;

  cfg_t cfg;

  smpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        out_data_nxt;
  logic        advance;

  logic [7:0]  tick_r, tick_nxt;
  logic [15:0] period_r, period_nxt;
  logic [7:0]  angle_front_r, angle_front_nxt;
  logic [7:0]  angle_back_r, angle_back_nxt;
  logic [7:0]  duty_r, duty_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic [7:0]  pattern_r, pattern_nxt;
  logic        backwards_r, backwards_nxt;
  logic [1:0]  pins_r, pins_nxt;
  logic [7:0]  port_r, port_nxt;
  logic        pulse;
  logic [7:0]  tick_inc;
  logic [15:0] period_inc;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_inc   = tick_r + 8'd1;
  assign period_inc = period_r + 16'd1;

  always_comb begin
    tick_nxt        = tick_r;
    period_nxt      = period_r;
    angle_front_nxt = angle_front_r;
    angle_back_nxt  = angle_back_r;
    duty_nxt        = duty_r;
    limit_nxt       = limit_r;
    pattern_nxt     = pattern_r;
    backwards_nxt   = backwards_r;
    pins_nxt        = pins_r;
    port_nxt        = port_r;
    pulse           = 1'b0;
    case (s1_data_r.command)
      CMD_TICK: begin
        pins_nxt = {tick_inc < angle_back_r, tick_inc < angle_front_r};
        port_nxt = (tick_inc < duty_r) ? pattern_r : PAT_STOP;
        tick_nxt = tick_inc;
        if (tick_inc >= cfg.period_ticks) begin
          tick_nxt   = 8'd0;
          period_nxt = period_inc;
          if (period_inc >= cfg.timeout_periods) begin
            pulse      = 1'b1;
            period_nxt = 16'd0;
          end
        end
      end
      CMD_SET_FRONT: angle_front_nxt = s1_data_r.value;
      CMD_SET_BACK:  angle_back_nxt  = s1_data_r.value;
      CMD_INC_FRONT: begin
        if (angle_front_r != ANGLE_MAX && angle_front_r != ANGLE_TOP) begin
          angle_front_nxt = angle_front_r + 8'd1;
        end
      end
      CMD_DEC_FRONT: begin
        if (angle_front_r != 8'd0) begin
          angle_front_nxt = angle_front_r - 8'd1;
        end
      end
      CMD_INC_BACK: begin
        if (angle_back_r != ANGLE_MAX && angle_back_r != ANGLE_TOP) begin
          angle_back_nxt = angle_back_r + 8'd1;
        end
      end
      CMD_DEC_BACK: begin
        if (angle_back_r != 8'd0) begin
          angle_back_nxt = angle_back_r - 8'd1;
        end
      end
      CMD_MOTOR: begin
        case (s1_data_r.value)
          MOTOR_STOP: begin
            pattern_nxt = PAT_STOP;
            duty_nxt    = 8'd0;
          end
          MOTOR_FORWARD: begin
            pattern_nxt   = PAT_FORWARD;
            backwards_nxt = 1'b0;
          end
          MOTOR_BACKWARD: begin
            pattern_nxt   = PAT_BACKWARD;
            backwards_nxt = 1'b1;
          end
          MOTOR_LEFT: begin
            pattern_nxt = PAT_LEFT;
            duty_nxt    = limit_r;
          end
          MOTOR_RIGHT: begin
            pattern_nxt = PAT_RIGHT;
            duty_nxt    = limit_r;
          end
          default: pattern_nxt = pattern_r;
        endcase
      end
      CMD_SET_LIMIT: begin
        limit_nxt = s1_data_r.value;
        if (cfg.limit_follow) begin
          duty_nxt = s1_data_r.value;
        end
      end
      CMD_DUTY_LIMIT: duty_nxt = limit_r;
      CMD_ACCEL: begin
        if (pattern_r != PAT_STOP) begin
          if (duty_r <= limit_r) begin
            if (duty_r != DUTY_MAX) begin
              duty_nxt = duty_r + 8'd1;
            end
          end else begin
            duty_nxt = duty_r - 8'd1;
          end
        end
      end
      default: tick_nxt = tick_r;
    endcase
  end

  always_comb begin
    out_data_nxt.servo_front     = pins_nxt[0];
    out_data_nxt.servo_back      = pins_nxt[1];
    out_data_nxt.motor_port      = port_nxt;
    out_data_nxt.timeout_pulse   = pulse;
    out_data_nxt.speed_now       = duty_nxt;
    out_data_nxt.limit_now       = limit_nxt;
    out_data_nxt.direction_now   = pattern_nxt;
    out_data_nxt.reversed        = backwards_nxt;
    out_data_nxt.angle_front_now = angle_front_nxt;
    out_data_nxt.angle_back_now  = angle_back_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= 8'd0;
      period_r      <= 16'd0;
      angle_front_r <= ANGLE_RESET;
      angle_back_r  <= ANGLE_RESET;
      duty_r        <= 8'd0;
      limit_r       <= LIMIT_RESET;
      pattern_r     <= PAT_STOP;
      backwards_r   <= 1'b0;
      pins_r        <= 2'b00;
      port_r        <= 8'd0;
    end else if (advance) begin
      tick_r        <= tick_nxt;
      period_r      <= period_nxt;
      angle_front_r <= angle_front_nxt;
      angle_back_r  <= angle_back_nxt;
      duty_r        <= duty_nxt;
      limit_r       <= limit_nxt;
      pattern_r     <= pattern_nxt;
      backwards_r   <= backwards_nxt;
      pins_r        <= pins_nxt;
      port_r        <= port_nxt;
    end
  end

endmodule

FILE: hw/rtl/smpc_checker.sv
// Port-level checker of the PWM controller and its bind to the top level.
module smpc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input smpc_pkg::out_t out_data
);
  import smpc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid seen right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed or dropped.");

  a_pattern_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.direction_now == PAT_STOP ||
                   out_data.direction_now == PAT_FORWARD ||
                   out_data.direction_now == PAT_BACKWARD ||
                   out_data.direction_now == PAT_LEFT ||
                   out_data.direction_now == PAT_RIGHT))
    else $error("Direction pattern is not a legal drive code.");

  a_port_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.motor_port == 8'd0 ||
                   out_data.motor_port == PAT_FORWARD ||
                   out_data.motor_port == PAT_BACKWARD ||
                   out_data.motor_port == PAT_LEFT ||
                   out_data.motor_port == PAT_RIGHT))
    else $error("Motor port shows neither zero nor a drive pattern.");

endmodule

bind servo_motor_pwm_controller_unit smpc_checker u_smpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/servo_motor_pwm_controller_unit_tb.sv
// Self-checking testbench for the servo and motor PWM controller with a built-in predictor.
`timescale 1ns / 1ps

module servo_motor_pwm_controller_unit_tb;
  import smpc_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  servo_motor_pwm_controller_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the registers and the controller state.
  logic        auto_copy;
  logic [7:0]  ticks_per_period;
  logic [15:0] periods_per_timeout;
  logic [7:0]  tick_cnt;
  logic [15:0] period_cnt;
  logic [7:0]  front_angle;
  logic [7:0]  back_angle;
  logic [7:0]  duty;
  logic [7:0]  duty_cap;
  logic [7:0]  pattern;
  logic        going_back;
  logic [1:0]  pins;
  logic [7:0]  port_byte;

  out_t        pending_levels[$];
  out_t        want;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_len;
  bit          calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic reset_shadow();
    auto_copy           = 1'b0;
    ticks_per_period    = PERIOD_RESET;
    periods_per_timeout = TIMEOUT_RESET;
    tick_cnt            = '0;
    period_cnt          = '0;
    front_angle         = ANGLE_RESET;
    back_angle          = ANGLE_RESET;
    duty                = '0;
    duty_cap            = LIMIT_RESET;
    pattern             = PAT_STOP;
    going_back          = 1'b0;
    pins                = '0;
    port_byte           = '0;
  endtask

  function automatic out_t advance_controller(in_t w);
    out_t r;
    logic pulse;
    pulse = 1'b0;
    case (w.command)
      CMD_TICK: begin
        tick_cnt  = tick_cnt + 8'd1;
        pins      = {tick_cnt < back_angle, tick_cnt < front_angle};
        port_byte = (tick_cnt < duty) ? pattern : 8'h00;
        if (tick_cnt >= ticks_per_period) begin
          tick_cnt   = '0;
          period_cnt = period_cnt + 16'd1;
          if (period_cnt >= periods_per_timeout) begin
            pulse      = 1'b1;
            period_cnt = '0;
          end
        end
      end
      CMD_SET_FRONT: front_angle = w.value;
      CMD_SET_BACK:  back_angle = w.value;
      CMD_INC_FRONT: begin
        if (front_angle != ANGLE_MAX && front_angle != ANGLE_TOP) front_angle = front_angle + 8'd1;
      end
      CMD_DEC_FRONT: begin
        if (front_angle != 8'd0) front_angle = front_angle - 8'd1;
      end
      CMD_INC_BACK: begin
        if (back_angle != ANGLE_MAX && back_angle != ANGLE_TOP) back_angle = back_angle + 8'd1;
      end
      CMD_DEC_BACK: begin
        if (back_angle != 8'd0) back_angle = back_angle - 8'd1;
      end
      CMD_MOTOR: begin
        case (w.value)
          MOTOR_STOP: begin
            pattern = PAT_STOP;
            duty    = '0;
          end
          MOTOR_FORWARD: begin
            pattern    = PAT_FORWARD;
            going_back = 1'b0;
          end
          MOTOR_BACKWARD: begin
            pattern    = PAT_BACKWARD;
            going_back = 1'b1;
          end
          MOTOR_LEFT: begin
            pattern = PAT_LEFT;
            duty    = duty_cap;
          end
          MOTOR_RIGHT: begin
            pattern = PAT_RIGHT;
            duty    = duty_cap;
          end
          default: ;
        endcase
      end
      CMD_SET_LIMIT: begin
        duty_cap = w.value;
        if (auto_copy) duty = duty_cap;
      end
      CMD_DUTY_LIMIT: duty = duty_cap;
      CMD_ACCEL: begin
        if (pattern != PAT_STOP) begin
          if (duty <= duty_cap) begin
            if (duty != DUTY_MAX) duty = duty + 8'd1;
          end else begin
            duty = duty - 8'd1;
          end
        end
      end
      default: ;
    endcase
    r.servo_front     = pins[0];
    r.servo_back      = pins[1];
    r.motor_port      = port_byte;
    r.timeout_pulse   = pulse;
    r.speed_now       = duty;
    r.limit_now       = duty_cap;
    r.direction_now   = pattern;
    r.reversed        = going_back;
    r.angle_front_now = front_angle;
    r.angle_back_now  = back_angle;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] exp_val);
    $display("t=%0t %s mismatch: got %0h, wanted %0h", $time, field, got, exp_val);
    mismatch_count++;
  endtask

  task automatic compare_levels(out_t got, out_t exp_word);
    if (got.servo_front !== exp_word.servo_front)
      report_mismatch("servo_front", 8'(got.servo_front), 8'(exp_word.servo_front));
    if (got.servo_back !== exp_word.servo_back)
      report_mismatch("servo_back", 8'(got.servo_back), 8'(exp_word.servo_back));
    if (got.motor_port !== exp_word.motor_port)
      report_mismatch("motor_port", got.motor_port, exp_word.motor_port);
    if (got.timeout_pulse !== exp_word.timeout_pulse)
      report_mismatch("timeout_pulse", 8'(got.timeout_pulse), 8'(exp_word.timeout_pulse));
    if (got.speed_now !== exp_word.speed_now)
      report_mismatch("speed_now", got.speed_now, exp_word.speed_now);
    if (got.limit_now !== exp_word.limit_now)
      report_mismatch("limit_now", got.limit_now, exp_word.limit_now);
    if (got.direction_now !== exp_word.direction_now)
      report_mismatch("direction_now", got.direction_now, exp_word.direction_now);
    if (got.reversed !== exp_word.reversed)
      report_mismatch("reversed", 8'(got.reversed), 8'(exp_word.reversed));
    if (got.angle_front_now !== exp_word.angle_front_now)
      report_mismatch("angle_front_now", got.angle_front_now, exp_word.angle_front_now);
    if (got.angle_back_now !== exp_word.angle_back_now)
      report_mismatch("angle_back_now", got.angle_back_now, exp_word.angle_back_now);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected word", 8'h00, 8'h00);
      end else begin
        want = pending_levels.pop_front();
        compare_levels(out_data, want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus a long hold-off when one is requested.
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
      end else begin
        n = 0;
      end
      out_ready <= (n == 0);
      repeat ((n == 0) ? 1 : n) @(negedge clk);
    end
  end

  task automatic send_word(input in_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_levels.push_back(advance_controller(w));
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [3:0] command, logic [7:0] value);
    in_t w;
    w.command = command;
    w.value   = value;
    send_word(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LIMIT_FOLLOW: auto_copy = data[0];
      REG_PERIOD:       ticks_per_period = data[7:0];
      REG_TIMEOUT:      periods_per_timeout = data[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic auto_on, logic [7:0] period, logic [15:0] timeout);
    write_register(REG_LIMIT_FOLLOW, {31'd0, auto_on});
    write_register(REG_PERIOD, {24'd0, period});
    write_register(REG_TIMEOUT, {16'd0, timeout});
  endtask

  function automatic in_t random_word();
    in_t         w;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    w.value = 8'($urandom_range(0, 255));
    if (pick < 55) begin
      w.command = CMD_TICK;
    end else if (pick < 92) begin
      w.command = 4'($urandom_range(1, 10));
      if (w.command == CMD_MOTOR && $urandom_range(0, 3) != 0)
        w.value = 8'($urandom_range(0, 4));
      else if ((w.command == CMD_SET_FRONT || w.command == CMD_SET_BACK) &&
               $urandom_range(0, 3) != 0)
        w.value = 8'($urandom_range(0, 30));
      else if (w.command == CMD_SET_LIMIT && $urandom_range(0, 1) != 0)
        w.value = 8'($urandom_range(0, 40));
    end else begin
      w.command = 4'($urandom_range(0, 15));
    end
    return w;
  endfunction

  task automatic test_servo_angles();
    send_cmd(CMD_TICK, 8'hFF);
    send_cmd(CMD_SET_FRONT, 8'd0);
    send_cmd(CMD_DEC_FRONT, 8'h00);
    send_cmd(CMD_SET_BACK, ANGLE_TOP);
    send_cmd(CMD_INC_BACK, 8'h00);
    send_cmd(CMD_DEC_BACK, 8'h00);
    send_cmd(CMD_SET_FRONT, ANGLE_MAX);
    send_cmd(CMD_INC_FRONT, 8'h00);
    settle();
  endtask

  task automatic test_motor_and_speed();
    send_cmd(CMD_ACCEL, 8'h00);
    send_cmd(CMD_MOTOR, MOTOR_LEFT);
    send_cmd(CMD_MOTOR, MOTOR_RIGHT);
    send_cmd(CMD_MOTOR, 8'd5);
    send_cmd(CMD_MOTOR, 8'd255);
    send_cmd(CMD_MOTOR, MOTOR_BACKWARD);
    send_cmd(CMD_MOTOR, MOTOR_FORWARD);
    send_cmd(CMD_SET_LIMIT, 8'd255);
    send_cmd(CMD_DUTY_LIMIT, 8'h00);
    send_cmd(CMD_ACCEL, 8'h00);
    send_cmd(CMD_SET_LIMIT, 8'd0);
    send_cmd(CMD_ACCEL, 8'h00);
    send_cmd(CMD_MOTOR, MOTOR_STOP);
    send_cmd(4'd15, 8'hFF);
    send_cmd(4'd11, 8'h00);
    settle();
  endtask

  task automatic test_period_edges();
    configure(1'b0, 8'd0, 16'd0);
    repeat (3) send_cmd(CMD_TICK, 8'h00);
    settle();
    configure(1'b1, 8'd255, 16'd65535);
    send_cmd(CMD_SET_LIMIT, 8'd7);
    send_cmd(CMD_MOTOR, MOTOR_FORWARD);
    repeat (8) send_cmd(CMD_TICK, 8'h00);
    settle();
    // The period shrinks below the running tick count here.
    write_register(REG_PERIOD, 32'd3);
    repeat (2) send_cmd(CMD_TICK, 8'h00);
    settle();
  endtask

  task automatic test_random_phase(int unsigned count, logic auto_on, logic [7:0] period,
                                   logic [15:0] timeout);
    configure(auto_on, period, timeout);
    repeat (count) send_word(random_word());
    settle();
  endtask

  task automatic test_output_backpressure();
    configure(1'b0, 8'd12, 16'd2);
    hold_len = 40;
    repeat (40) send_word(random_word());
    settle();
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_phase(200, 1'b1, 8'd10, 16'd2);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_len       = 0;
    calm           = 1'b0;
    reset_shadow();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_servo_angles();
    test_motor_and_speed();
    test_period_edges();
    test_random_phase(250, 1'b0, 8'd1, 16'd1);
    test_random_phase(400, 1'b1, 8'd20, 16'd3);
    test_random_phase(400, 1'b0, 8'd30, 16'd2);
    test_random_phase(250, 1'b1, 8'd255, 16'd65535);
    test_random_phase(400, 1'b0, 8'($urandom_range(1, 40)), 16'($urandom_range(1, 5)));
    test_output_backpressure();
    test_steady_stream();

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: servo_motor_pwm_controller_unit.f
hw/rtl/smpc_pkg.sv
hw/rtl/smpc_cfg.sv
hw/rtl/servo_motor_pwm_controller_unit.sv
hw/rtl/smpc_checker.sv
tb/servo_motor_pwm_controller_unit_tb.sv
